// ===== rtl/cdr_pkg.sv =====
// ----------------------------------------------------------------------------
// cdr_pkg
// Types and constants shared by the domain ranking controller and datapath.
// ----------------------------------------------------------------------------
package cdr_pkg;

    localparam logic [1:0] MODE_CENTROID = 2'd0;
    localparam logic [1:0] MODE_QUERY    = 2'd1;
    localparam logic [1:0] MODE_TARGET   = 2'd2;

    localparam int SCORE_W = 39;
    localparam logic signed [SCORE_W-1:0] MINUS_ONE = -(39'sd1 <<< 30);

    localparam logic [0:0] REG_VECTOR_DIM = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_RANK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  domain;
        logic [2:0]  slot;
        logic [6:0]  element_index;
        logic [15:0] value;
        logic        target_valid;
        logic [31:0] query_tag;
        logic        last;
    } item_t;

    typedef struct packed {
        logic take;
        logic score_start;
        logic rank_start;
        logic out_clear;
    } cmd_t;

    typedef struct packed {
        logic score_done;
        logic rank_done;
        logic has_result;
    } status_t;

endpackage

// ===== rtl/cdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdr_ctrl
// Sequencer that accepts items, starts scoring and ranking, and hands off
// results.
// ----------------------------------------------------------------------------
module cdr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  cdr_pkg::item_t   item,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    output cdr_pkg::cmd_t    cmd,
    input  cdr_pkg::status_t sts
);
    import cdr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd             = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take = 1'b1;
                    if (item.mode == MODE_QUERY && item.last) begin
                        cmd.score_start = 1'b1;
                        state_next = ST_SCORE;
                    end else if (item.mode == MODE_TARGET) begin
                        cmd.rank_start = 1'b1;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_SCORE: begin
                if (sts.score_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RANK: begin
                if (sts.rank_done) begin
                    state_next = sts.has_result ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.out_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cdr_datapath.sv =====
// ----------------------------------------------------------------------------
// cdr_datapath
// Centroid and query stores, one multiply-accumulate per cycle for scoring,
// and a one-domain-per-cycle rank counter.
// ----------------------------------------------------------------------------
module cdr_datapath #(
    parameter int DOMAINS              = 16,
    parameter int CENTROIDS_PER_DOMAIN = 8,
    parameter int MAX_DIM              = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cdr_pkg::item_t                  item,
    input  cdr_pkg::cmd_t                   cmd,
    input  logic [7:0]                      vector_dim,
    output cdr_pkg::status_t                sts,
    output logic [31:0]                     res_query_id,
    output logic [7:0]                      res_num_targets,
    output logic [4:0]                      res_best_rank,
    output logic signed [38:0]              res_best_score,
    output logic signed [38:0]              res_top_score,
    output logic signed [39:0]              res_gap
);
    import cdr_pkg::*;

    localparam int DW   = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam int SW   = (CENTROIDS_PER_DOMAIN > 1) ? $clog2(CENTROIDS_PER_DOMAIN) : 1;
    localparam int EW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ROWS = DOMAINS * CENTROIDS_PER_DOMAIN;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW   = (ROWS * MAX_DIM > 1) ? $clog2(ROWS * MAX_DIM) : 1;
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int KW   = $clog2(DOMAINS + 2);
    localparam logic [KW-1:0] NO_RANK = KW'(DOMAINS + 1);

    logic signed [15:0] cent_mem [ROWS*MAX_DIM];
    logic signed [15:0] query_mem [MAX_DIM];
    logic signed [SCORE_W-1:0] score_mem [DOMAINS];
    logic [ROWS-1:0]    slot_valid_reg;
    logic [DOMAINS-1:0] scored_reg;

    logic [CW-1:0] dim_eff;
    assign dim_eff = (32'(vector_dim) > MAX_DIM) ? CW'(MAX_DIM) : CW'(vector_dim);

    logic in_cent;
    assign in_cent = (32'(item.domain) < DOMAINS) && (32'(item.slot) < CENTROIDS_PER_DOMAIN)
                     && (32'(item.element_index) < MAX_DIM);
    logic [RW-1:0] wr_row;
    assign wr_row = RW'(32'(item.domain) * CENTROIDS_PER_DOMAIN + 32'(item.slot));
    logic [AW-1:0] wr_addr;
    assign wr_addr = AW'(32'(wr_row) * MAX_DIM + 32'(item.element_index));

    // Scoring sequencer: domain, slot, element.
    logic          sc_busy_reg;
    logic [DW-1:0] sd_reg;
    logic [SW-1:0] ss_reg;
    logic [CW-1:0] se_reg;
    logic          rd_v_reg, rd_last_reg, rd_slot_ok_reg;
    logic [DW-1:0] rd_dom_reg;
    logic          rd_slot_last_reg;
    logic signed [15:0] q_rd_reg, c_rd_reg;
    logic          p_v_reg, p_last_reg, p_ok_reg, p_slot_last_reg;
    logic [DW-1:0] p_dom_reg;
    logic signed [31:0] prod_reg;
    logic signed [SCORE_W-1:0] acc_reg, best_reg, top_reg;
    logic          any_reg, present_reg;
    logic          sc_done_reg;

    logic [RW-1:0] rd_row;
    assign rd_row = RW'(32'(sd_reg) * CENTROIDS_PER_DOMAIN + 32'(ss_reg));
    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(32'(rd_row) * MAX_DIM + 32'(se_reg));
    logic row_ok;
    assign row_ok = slot_valid_reg[rd_row];
    logic last_elem, last_slot, last_dom;
    assign last_elem = (dim_eff == 0) || (se_reg == dim_eff - CW'(1));
    assign last_slot = (32'(ss_reg) == CENTROIDS_PER_DOMAIN - 1);
    assign last_dom  = (32'(sd_reg) == DOMAINS - 1);

    // Slot validity at the end of each slot pass travels through its own
    // pipeline so that a zero-length vector still marks the domain present.
    logic sv_rd_reg, sv_p_reg;
    always_ff @(posedge aclk) begin
        sv_rd_reg <= row_ok;
        sv_p_reg  <= sv_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && item.mode == MODE_CENTROID && in_cent) begin
            cent_mem[wr_addr] <= item.value;
        end
        if (cmd.take && item.mode == MODE_QUERY && 32'(item.element_index) < MAX_DIM) begin
            query_mem[EW'(item.element_index)] <= item.value;
        end
        q_rd_reg <= query_mem[EW'(se_reg)];
        c_rd_reg <= cent_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            scored_reg     <= '0;
            sc_busy_reg    <= 1'b0;
            rd_v_reg       <= 1'b0;
            p_v_reg        <= 1'b0;
            sc_done_reg    <= 1'b0;
            top_reg        <= '0;
            sd_reg         <= '0;
            ss_reg         <= '0;
            se_reg         <= '0;
        end else begin
            sc_done_reg <= 1'b0;
            if (cmd.take && item.mode == MODE_CENTROID && in_cent && item.last) begin
                slot_valid_reg[wr_row] <= 1'b1;
            end
            if (cmd.score_start) begin
                sc_busy_reg <= 1'b1;
                sd_reg <= '0;
                ss_reg <= '0;
                se_reg <= '0;
                top_reg <= '0;
                any_reg <= 1'b0;
                acc_reg <= '0;
                best_reg <= MINUS_ONE;
                present_reg <= 1'b0;
            end
            rd_v_reg <= sc_busy_reg;
            if (sc_busy_reg) begin
                rd_dom_reg <= sd_reg;
                rd_slot_ok_reg <= row_ok && dim_eff != 0;
                rd_slot_last_reg <= last_elem;
                rd_last_reg <= last_elem && last_slot;
                if (!last_elem) begin
                    se_reg <= se_reg + CW'(1);
                end else begin
                    se_reg <= '0;
                    if (!last_slot) begin
                        ss_reg <= ss_reg + SW'(1);
                    end else begin
                        ss_reg <= '0;
                        if (last_dom) begin
                            sc_busy_reg <= 1'b0;
                        end else begin
                            sd_reg <= sd_reg + DW'(1);
                        end
                    end
                end
            end
            // Row validity is registered alongside the read data.
            p_v_reg <= rd_v_reg;
            p_ok_reg <= rd_slot_ok_reg;
            p_last_reg <= rd_last_reg;
            p_slot_last_reg <= rd_slot_last_reg;
            p_dom_reg <= rd_dom_reg;
            prod_reg <= q_rd_reg * c_rd_reg;
            if (p_v_reg) begin
                logic signed [SCORE_W-1:0] a, b;
                logic pres;
                a = p_ok_reg ? acc_reg + SCORE_W'(prod_reg) : '0;
                b = best_reg;
                pres = present_reg;
                if (p_slot_last_reg) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= a;
                end
                if (p_slot_last_reg && sv_p_reg) begin
                    pres = 1'b1;
                    if (a > b) b = a;
                end
                if (p_slot_last_reg && p_last_reg) begin
                    scored_reg[p_dom_reg] <= pres;
                    score_mem[p_dom_reg] <= pres ? b : '0;
                    if (pres && (!any_reg || b > top_reg)) begin
                        top_reg <= b;
                        any_reg <= 1'b1;
                    end
                    best_reg <= MINUS_ONE;
                    present_reg <= 1'b0;
                    if (32'(p_dom_reg) == DOMAINS - 1) sc_done_reg <= 1'b1;
                end else begin
                    best_reg <= b;
                    present_reg <= pres;
                end
            end
        end
    end

    // Target ranking: one domain per cycle.
    logic          rk_busy_reg, rk_do_reg, rk_last_reg, rk_done_reg;
    logic [DW-1:0] rk_idx_reg;
    logic [KW-1:0] rk_cnt_reg;
    logic signed [SCORE_W-1:0] rk_sc_reg;
    logic [7:0]    tcount_reg;
    logic [KW-1:0] best_rank_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [31:0]   qid_reg;
    logic          tgt_ok;
    assign tgt_ok = item.target_valid && (32'(item.domain) < DOMAINS)
                    && scored_reg[DW'(item.domain)];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rk_busy_reg <= 1'b0;
            rk_done_reg <= 1'b0;
            tcount_reg <= '0;
            best_rank_reg <= NO_RANK;
            best_score_reg <= MINUS_ONE;
        end else begin
            rk_done_reg <= 1'b0;
            if (sc_done_reg || cmd.out_clear) begin
                tcount_reg <= '0;
                best_rank_reg <= NO_RANK;
                best_score_reg <= MINUS_ONE;
            end
            if (cmd.rank_start) begin
                if (tcount_reg != 8'd255) tcount_reg <= tcount_reg + 8'd1;
                rk_busy_reg <= 1'b1;
                rk_do_reg <= tgt_ok;
                rk_last_reg <= item.last;
                qid_reg <= item.query_tag;
                rk_idx_reg <= '0;
                rk_cnt_reg <= KW'(1);
                rk_sc_reg <= score_mem[DW'(item.domain)];
            end else if (rk_busy_reg) begin
                if (scored_reg[rk_idx_reg] && score_mem[rk_idx_reg] > rk_sc_reg) begin
                    rk_cnt_reg <= rk_cnt_reg + KW'(1);
                end
                if (32'(rk_idx_reg) == DOMAINS - 1) begin
                    rk_busy_reg <= 1'b0;
                    rk_done_reg <= 1'b1;
                end else begin
                    rk_idx_reg <= rk_idx_reg + DW'(1);
                end
            end
            if (rk_done_reg && rk_do_reg && rk_cnt_reg < best_rank_reg) begin
                best_rank_reg <= rk_cnt_reg;
                best_score_reg <= rk_sc_reg;
            end
        end
    end

    logic rk_fin_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) rk_fin_reg <= 1'b0;
        else rk_fin_reg <= rk_done_reg;
    end

    assign sts.score_done = sc_done_reg;
    assign sts.rank_done  = rk_fin_reg;
    assign sts.has_result = rk_last_reg;

    assign res_query_id    = qid_reg;
    assign res_num_targets = tcount_reg;
    assign res_best_rank   = 5'(best_rank_reg);
    assign res_best_score  = best_score_reg;
    assign res_top_score   = top_reg;
    assign res_gap         = 40'(top_reg) - 40'(best_score_reg);

endmodule

// ===== rtl/centroid_domain_rank.sv =====
// ----------------------------------------------------------------------------
// centroid_domain_rank
// Ranks stored centroid domains against a query by maximum inner product.
// ----------------------------------------------------------------------------
// Centroid and query elements are taken while idle. A query's last element
// starts scoring over every domain, slot and element (one step for a slot
// when dim is zero), one MAC per cycle. A target is ranked by the
// one-domain-per-cycle compare; the result of a list's last target is then
// held on the output until it is taken.
// Reset is synchronous, active low; slot valid bits clear at once.
module centroid_domain_rank #(
    parameter int DOMAINS              = 16,
    parameter int CENTROIDS_PER_DOMAIN = 8,
    parameter int MAX_DIM              = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // domain, slot, element_index, value, query id
    input  logic [63:0]   s_tdata,
    // mode, target_valid
    input  logic [2:0]    s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // result id, num_targets, best_rank, best_score, top score, score_gap
    output logic [167:0]  m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import cdr_pkg::*;

    item_t   item;
    cmd_t    cmd;
    status_t sts;
    logic [7:0] vector_dim_reg;

    assign item.mode          = s_tuser[1:0];
    assign item.domain        = s_tdata[3:0];
    assign item.slot          = s_tdata[6:4];
    assign item.element_index = s_tdata[13:7];
    assign item.value         = s_tdata[29:14];
    assign item.target_valid  = s_tuser[2];
    assign item.query_tag     = s_tdata[61:30];
    assign item.last          = s_tlast;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VECTOR_DIM) ? {24'd0, vector_dim_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_dim_reg <= 8'd128;
        end else if (psel && penable && pwrite && paddr[2] == REG_VECTOR_DIM) begin
            vector_dim_reg <= pwdata[7:0];
        end
    end

    cdr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .item      (item),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd),
        .sts       (sts)
    );

    logic [31:0] r_qid;
    logic [7:0]  r_nt;
    logic [4:0]  r_rank;
    logic signed [38:0] r_best, r_top;
    logic signed [39:0] r_gap;

    cdr_datapath #(
        .DOMAINS              (DOMAINS),
        .CENTROIDS_PER_DOMAIN (CENTROIDS_PER_DOMAIN),
        .MAX_DIM              (MAX_DIM)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item            (item),
        .cmd             (cmd),
        .vector_dim      (vector_dim_reg),
        .sts             (sts),
        .res_query_id    (r_qid),
        .res_num_targets (r_nt),
        .res_best_rank   (r_rank),
        .res_best_score  (r_best),
        .res_top_score   (r_top),
        .res_gap         (r_gap)
    );

    assign m_tdata = {5'd0, r_gap, r_top, r_best, r_rank, r_nt, r_qid};

endmodule
